// ===== design/tpahit_pkg.sv =====
package tpahit_pkg;

  // header bytes that open a touch packet
  localparam logic [7:0] HDR_A = 8'h81;
  localparam logic [7:0] HDR_B = 8'h80;

  // field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned BTN_W   = 2;
  localparam int unsigned CFG_IDX_W = 4;

  // parse phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_XHI  = 3'd1;
  localparam logic [2:0] PH_XLO  = 3'd2;
  localparam logic [2:0] PH_YHI  = 3'd3;
  localparam logic [2:0] PH_YLO  = 3'd4;

  // button codes
  localparam logic [BTN_W-1:0] BTN_NONE   = 2'd0;
  localparam logic [BTN_W-1:0] BTN_TIME   = 2'd1;
  localparam logic [BTN_W-1:0] BTN_STATUS = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_X_LOW    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_X_HIGH   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_Y_LOW    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_Y_HIGH   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_X_LOW  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_X_HIGH = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_Y_LOW  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_Y_HIGH = 4'd7;

  // register reset values
  localparam logic [COORD_W-1:0] RST_TIME_X_LOW    = 16'd2350;
  localparam logic [COORD_W-1:0] RST_TIME_X_HIGH   = 16'd2820;
  localparam logic [COORD_W-1:0] RST_TIME_Y_LOW    = 16'd1650;
  localparam logic [COORD_W-1:0] RST_TIME_Y_HIGH   = 16'd2070;
  localparam logic [COORD_W-1:0] RST_STATUS_X_LOW  = 16'd2350;
  localparam logic [COORD_W-1:0] RST_STATUS_X_HIGH = 16'd2820;
  localparam logic [COORD_W-1:0] RST_STATUS_Y_LOW  = 16'd1130;
  localparam logic [COORD_W-1:0] RST_STATUS_Y_HIGH = 16'd1570;

  typedef struct packed {
    logic [COORD_W-1:0] x_low;
    logic [COORD_W-1:0] x_high;
    logic [COORD_W-1:0] y_low;
    logic [COORD_W-1:0] y_high;
  } rect_t;

  function automatic logic in_rect(input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y,
                                   input rect_t r);
    in_rect = (x >= r.x_low) && (x <= r.x_high) && (y >= r.y_low) && (y <= r.y_high);
  endfunction

endpackage

// ===== design/touch_packet_average_hit_test_unit.sv =====
// a byte without tlast is parsed and s_tready stays high
// a byte with tlast starts a bit-serial restoring divide of both sums by the packet
// count, then the hit test, then the result sits in the output register
// no new byte is taken until that result is in the output register (s_tready low)
// reset: rst clears the parse state, the output valid and loads the default rectangles
module touch_packet_average_hit_test_unit #(
  parameter int PACKETS_PER_READING = 5
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // buffer_end
  // result out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] touch_x, [31:16] touch_y,
                                 // [34:32] packet_count, [36:35] pressed_button, zero fill
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW = tpahit_pkg::COORD_W;
  localparam int unsigned NW = tpahit_pkg::COUNT_W;
  localparam int unsigned BIT_CNT_W = $clog2(CW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // button rectangles
  tpahit_pkg::rect_t time_rect;
  tpahit_pkg::rect_t status_rect;

  // parse state
  logic [2:0]    parse_phase;
  logic [7:0]    held_high_byte;
  logic [CW-1:0] held_x;
  logic [CW-1:0] sum_x;
  logic [CW-1:0] sum_y;
  logic [NW-1:0] packets_seen;

  logic [2:0]    parse_phase_next;
  logic [7:0]    held_high_byte_next;
  logic [CW-1:0] held_x_next;
  logic [CW-1:0] sum_x_next;
  logic [CW-1:0] sum_y_next;
  logic [NW-1:0] packets_seen_next;

  // serial divider: quotient shifts in from the bottom as the dividend shifts out the top
  logic [CW-1:0]        quo_x;
  logic [CW-1:0]        quo_y;
  logic [NW-1:0]        rem_x;
  logic [NW-1:0]        rem_y;
  logic [NW-1:0]        div_cnt;
  logic [BIT_CNT_W-1:0] bit_cnt;

  logic [NW:0]   rsh_x;
  logic [NW:0]   rsh_y;
  logic          ge_x;
  logic          ge_y;

  logic [CW-1:0] avg_x;
  logic [CW-1:0] avg_y;
  logic [tpahit_pkg::BTN_W-1:0] btn;

  // output register
  logic [CW-1:0] out_x;
  logic [CW-1:0] out_y;
  logic [NW-1:0] out_cnt;
  logic [tpahit_pkg::BTN_W-1:0] out_btn;

  logic in_req;
  logic out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_req    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {3'b000, out_btn, out_cnt, out_y, out_x};

  // packet parser, one byte per request
  always_comb begin
    parse_phase_next    = parse_phase;
    held_high_byte_next = held_high_byte;
    held_x_next         = held_x;
    sum_x_next          = sum_x;
    sum_y_next          = sum_y;
    packets_seen_next   = packets_seen;
    unique case (parse_phase)
      tpahit_pkg::PH_HUNT: begin
        if ((packets_seen < NW'(PACKETS_PER_READING)) &&
            (s_tdata == tpahit_pkg::HDR_A || s_tdata == tpahit_pkg::HDR_B)) begin
          parse_phase_next = tpahit_pkg::PH_XHI;
        end
      end
      tpahit_pkg::PH_XHI: begin
        held_high_byte_next = s_tdata;
        parse_phase_next    = tpahit_pkg::PH_XLO;
      end
      tpahit_pkg::PH_XLO: begin
        held_x_next      = {held_high_byte, s_tdata};
        parse_phase_next = tpahit_pkg::PH_YHI;
      end
      tpahit_pkg::PH_YHI: begin
        held_high_byte_next = s_tdata;
        parse_phase_next    = tpahit_pkg::PH_YLO;
      end
      tpahit_pkg::PH_YLO: begin
        sum_x_next        = sum_x + held_x;
        sum_y_next        = sum_y + {held_high_byte, s_tdata};
        packets_seen_next = packets_seen + NW'(1);
        parse_phase_next  = tpahit_pkg::PH_HUNT;
      end
      default: begin
        parse_phase_next = tpahit_pkg::PH_HUNT;
      end
    endcase
  end

  // one restoring step for each coordinate
  always_comb begin
    rsh_x = {rem_x, quo_x[CW-1]};
    rsh_y = {rem_y, quo_y[CW-1]};
    ge_x  = rsh_x >= {1'b0, div_cnt};
    ge_y  = rsh_y >= {1'b0, div_cnt};
  end

  // zero packets gives a zero average
  assign avg_x = (div_cnt == '0) ? '0 : quo_x;
  assign avg_y = (div_cnt == '0) ? '0 : quo_y;

  // first rectangle wins
  always_comb begin
    if (tpahit_pkg::in_rect(avg_x, avg_y, time_rect)) begin
      btn = tpahit_pkg::BTN_TIME;
    end else if (tpahit_pkg::in_rect(avg_x, avg_y, status_rect)) begin
      btn = tpahit_pkg::BTN_STATUS;
    end else begin
      btn = tpahit_pkg::BTN_NONE;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      time_rect.x_low    <= tpahit_pkg::RST_TIME_X_LOW;
      time_rect.x_high   <= tpahit_pkg::RST_TIME_X_HIGH;
      time_rect.y_low    <= tpahit_pkg::RST_TIME_Y_LOW;
      time_rect.y_high   <= tpahit_pkg::RST_TIME_Y_HIGH;
      status_rect.x_low  <= tpahit_pkg::RST_STATUS_X_LOW;
      status_rect.x_high <= tpahit_pkg::RST_STATUS_X_HIGH;
      status_rect.y_low  <= tpahit_pkg::RST_STATUS_Y_LOW;
      status_rect.y_high <= tpahit_pkg::RST_STATUS_Y_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpahit_pkg::REG_TIME_X_LOW:    time_rect.x_low    <= cfg_data;
        tpahit_pkg::REG_TIME_X_HIGH:   time_rect.x_high   <= cfg_data;
        tpahit_pkg::REG_TIME_Y_LOW:    time_rect.y_low    <= cfg_data;
        tpahit_pkg::REG_TIME_Y_HIGH:   time_rect.y_high   <= cfg_data;
        tpahit_pkg::REG_STATUS_X_LOW:  status_rect.x_low  <= cfg_data;
        tpahit_pkg::REG_STATUS_X_HIGH: status_rect.x_high <= cfg_data;
        tpahit_pkg::REG_STATUS_Y_LOW:  status_rect.y_low  <= cfg_data;
        tpahit_pkg::REG_STATUS_Y_HIGH: status_rect.y_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // control, parser state, divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      parse_phase    <= tpahit_pkg::PH_HUNT;
      held_high_byte <= '0;
      held_x         <= '0;
      sum_x          <= '0;
      sum_y          <= '0;
      packets_seen   <= '0;
      div_cnt        <= '0;
      bit_cnt        <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_req) begin
            if (s_tlast) begin
              // hand the finished sums to the divider, start a fresh buffer
              quo_x          <= sum_x_next;
              quo_y          <= sum_y_next;
              rem_x          <= '0;
              rem_y          <= '0;
              div_cnt        <= packets_seen_next;
              bit_cnt        <= '1;
              parse_phase    <= tpahit_pkg::PH_HUNT;
              held_high_byte <= '0;
              held_x         <= '0;
              sum_x          <= '0;
              sum_y          <= '0;
              packets_seen   <= '0;
              state          <= ST_DIV;
            end else begin
              parse_phase    <= parse_phase_next;
              held_high_byte <= held_high_byte_next;
              held_x         <= held_x_next;
              sum_x          <= sum_x_next;
              sum_y          <= sum_y_next;
              packets_seen   <= packets_seen_next;
            end
          end
        end
        ST_DIV: begin
          quo_x   <= {quo_x[CW-2:0], ge_x};
          quo_y   <= {quo_y[CW-2:0], ge_y};
          rem_x   <= ge_x ? NW'(rsh_x - {1'b0, div_cnt}) : rsh_x[NW-1:0];
          rem_y   <= ge_y ? NW'(rsh_y - {1'b0, div_cnt}) : rsh_y[NW-1:0];
          bit_cnt <= bit_cnt - BIT_CNT_W'(1);
          if (bit_cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_x    <= avg_x;
            out_y    <= avg_y;
            out_cnt  <= div_cnt;
            out_btn  <= btn;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    packets_seen <= NW'(PACKETS_PER_READING))
    else $error("packet count beyond limit");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    parse_phase <= tpahit_pkg::PH_YLO)
    else $error("parse phase out of range");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) && (bit_cnt == '0) |=> (state == ST_DONE))
    else $error("divider did not finish after its last step");

  a_zero_avg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_cnt == '0) |-> (out_x == '0) && (out_y == '0))
    else $error("nonzero average with no packets");

  a_btn_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_btn == tpahit_pkg::BTN_NONE || out_btn == tpahit_pkg::BTN_TIME ||
                  out_btn == tpahit_pkg::BTN_STATUS))
    else $error("bad button code");

endmodule
